/* hdl/rgbhsi_pkg.sv */
package rgbhsi_pkg;

  localparam int unsigned AngleFracBitsDef = 16;
  localparam int unsigned AtanTableBits    = 24;
  localparam int unsigned AtanSteps        = 25;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [6:0] sat_pct;
    logic [7:0] inten;
  } pix_out_t;

  // atan(2^-i) in degrees, scaled by 2^24
  localparam longint AtanDegQ24 [AtanSteps] = '{
    754974720, 445687602, 235489088, 119537938, 60000934,
    30029717,  15018523,  7509720,   3754917,   1877466,
    938734,    469367,    234684,    117342,    58671,
    29335,     14668,     7334,      3667,      1833,
    917,       458,       229,       115,       57
  };

  // arctangent constant of one step at frac_bits fractional bits, round half up
  function automatic longint atan_step(int unsigned idx, int unsigned frac_bits);
    int unsigned sh;
    longint      t;
    sh = AtanTableBits - frac_bits;
    t  = AtanDegQ24[idx];
    if (sh == 0) begin
      return t;
    end
    return (t + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // integer square root, used on constants only
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned rem;
    longint unsigned bitv;
    res = 0;
    rem = v;
    for (int k = 31; k >= 0; k--) begin
      bitv = 64'd1 << (2 * k);
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

endpackage

/* hdl/rgb_to_hsi_pixel.sv */
// rgb to hsi conversion, one pixel per clock while the output is not stalled
// a request passes the input, preparation, cordic and output registers before result valid
// throughput: one pixel per cycle unless out_stall_i holds the pipeline, one cordic iteration per cordic stage
// each stage takes a new request once its content moves on, so bubbles close up
// reset: asynchronous, active low, clears all stage valid bits; data regs are not reset
module rgb_to_hsi_pixel #(
  parameter int unsigned ANGLE_FRAC_BITS = rgbhsi_pkg::AngleFracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rgbhsi_pkg::pix_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rgbhsi_pkg::pix_out_t out_data_o
);

  localparam int unsigned F  = ANGLE_FRAC_BITS;
  localparam int unsigned W  = F + 13;
  localparam int unsigned ZW = F + 11;
  localparam int unsigned NC = F + 2;
  localparam int unsigned SW = F + 2;
  localparam logic [SW-1:0] Sqrt3 = SW'(rgbhsi_pkg::isqrt(64'd3 << (2 * F)));
  localparam logic signed [ZW-1:0] Z90  = ZW'(90)  <<< F;
  localparam logic signed [ZW-1:0] Z180 = ZW'(180) <<< F;
  localparam logic signed [ZW-1:0] Z360 = ZW'(360) <<< F;

  typedef struct packed {
    logic signed [W-1:0]  x;
    logic signed [W-1:0]  y;
    logic signed [ZW-1:0] z;
    logic [16:0]          rem;
    logic [6:0]           quo;
    logic [9:0]           sum;
    logic [7:0]           inten;
    logic                 gray;
    logic                 lowsat;
    logic                 bneg;
  } stg_t;

  // one restoring division step for saturation
  function automatic stg_t div_step(stg_t s, int unsigned k);
    logic [16:0] dv;
    dv = 17'(s.sum) << k;
    if (s.rem >= dv) begin
      s.rem    = s.rem - dv;
      s.quo[k] = 1'b1;
    end
    return s;
  endfunction

  rgbhsi_pkg::pix_in_t  in_q;
  logic                 vin_q;
  stg_t                 pr_d, pr_q;
  logic                 vpr_q;
  stg_t                 cq [NC];
  logic [NC-1:0]        vc_q;
  rgbhsi_pkg::pix_out_t out_d, out_q;
  logic                 vout_q;

  logic                 en_in, en_pr, en_out;
  logic [NC-1:0]        en_c;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en_out       = !vout_q || !out_stall_i;
    en_c[NC-1]   = !vc_q[NC-1] || en_out;
    for (int j = NC - 2; j >= 0; j--) begin
      en_c[j] = !vc_q[j] || en_c[j+1];
    end
    en_pr = !vpr_q || en_c[0];
    en_in = !vin_q || en_pr;
  end

  assign in_stall_o = !en_in;

  // preparation: sums, extremes, intensity, gray and low saturation flags, cordic start vector, dividend
  always_comb begin
    logic [7:0]         r, g, b, mn, mx, d;
    logic [9:0]         s3mn;
    logic [19:0]        prod;
    logic signed [10:0] xi;
    r    = in_q.red_in;
    g    = in_q.green_in;
    b    = in_q.blue_in;
    mn   = (g < r) ? g : r;
    mn   = (b < mn) ? b : mn;
    mx   = (g > r) ? g : r;
    mx   = (b > mx) ? b : mx;
    d    = (g > b) ? (g - b) : (b - g);
    pr_d.sum    = 10'(r) + 10'(g) + 10'(b);
    s3mn        = 10'(mn) * 10'd3;
    pr_d.rem    = 17'(pr_d.sum - s3mn) * 17'd100;
    pr_d.quo    = '0;
    prod        = 20'(pr_d.sum) * 20'd683;
    pr_d.inten  = prod[18:11];
    pr_d.gray   = (mx == mn);
    pr_d.lowsat = (pr_d.rem <= 17'(pr_d.sum));
    pr_d.bneg   = (b > g);
    xi          = 11'(signed'({1'b0, r, 1'b0})) - 11'(g) - 11'(b);
    pr_d.x      = W'(xi) <<< F;
    pr_d.y      = signed'(W'(d) * W'(Sqrt3));
    pr_d.z      = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q  <= 1'b0;
      vpr_q  <= 1'b0;
      vc_q   <= '0;
      vout_q <= 1'b0;
    end else begin
      if (en_in)  vin_q  <= in_valid_i;
      if (en_pr)  vpr_q  <= vin_q;
      if (en_c[0]) vc_q[0] <= vpr_q;
      for (int j = 1; j < NC; j++) begin
        if (en_c[j]) vc_q[j] <= vc_q[j-1];
      end
      if (en_out) vout_q <= vc_q[NC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in) in_q <= in_data_i;
    if (en_pr) pr_q <= pr_d;
  end

  // quadrant fold: left half plane turned by -90 degrees, plus the first saturation division step
  always_ff @(posedge clk_i) begin
    stg_t t;
    t = pr_q;
    if (pr_q.x < 0) begin
      t.x = pr_q.y;
      t.y = -pr_q.x;
      t.z = Z90;
    end
    t = div_step(t, 6);
    if (en_c[0]) cq[0] <= t;
  end

  for (genvar j = 1; j < NC; j++) begin : g_cordic
    localparam int unsigned I = j - 1;
    localparam logic signed [ZW-1:0] Ang = ZW'(rgbhsi_pkg::atan_step(I, F));
    stg_t nxt;

    always_comb begin
      nxt = cq[j-1];
      if (cq[j-1].y >= 0) begin
        nxt.x = cq[j-1].x + (cq[j-1].y >>> I);
        nxt.y = cq[j-1].y - (cq[j-1].x >>> I);
        nxt.z = cq[j-1].z + Ang;
      end else begin
        nxt.x = cq[j-1].x - (cq[j-1].y >>> I);
        nxt.y = cq[j-1].y + (cq[j-1].x >>> I);
        nxt.z = cq[j-1].z - Ang;
      end
      if (j <= 6) begin
        nxt = div_step(nxt, 6 - j);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_c[j]) cq[j] <= nxt;
    end
  end

  // clamp angle, mirror for blue above green, whole degrees; hue zero for gray or low saturation
  always_comb begin
    logic signed [ZW-1:0] th, h;
    logic [8:0]           deg;
    th = cq[NC-1].z;
    if (th < 0) th = '0;
    if (th > Z180) th = Z180;
    h   = cq[NC-1].bneg ? (Z360 - th) : th;
    deg = h[F +: 9];
    if (deg >= 9'd360) deg = '0;
    if (cq[NC-1].gray || cq[NC-1].lowsat) deg = '0;
    out_d.hue_deg = deg;
    out_d.sat_pct = cq[NC-1].gray ? 7'd0 : cq[NC-1].quo;
    out_d.inten   = cq[NC-1].inten;
  end

  always_ff @(posedge clk_i) begin
    if (en_out) out_q <= out_d;
  end

  assign out_valid_o = vout_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_sat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.sat_pct <= 7'd100)
    else $error("saturation above 100");

  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.hue_deg < 9'd360)
    else $error("hue out of range");

  a_zero_sat_hue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.sat_pct == 7'd0) |-> out_data_o.hue_deg == 9'd0)
    else $error("hue set on unsaturated pixel");

  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vc_q[NC-1] && vout_q && out_stall_i) |=> vc_q[NC-1])
    else $error("pipeline request lost under stall");
`endif

endmodule
